// ===== rtl/core/rwlc_pkg.sv =====
// shared widths, region codes and candidate types for the window line clipper
package rwlc_pkg;

  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NUMW = 2 * CW + 2;
  localparam int DENW = CW + 1;
  localparam int DIV_STAGES = NUMW;
  localparam int SW = NUMW + 2;

  localparam logic [CW-1:0] WIN_LEFT_RST   = CW'(410);
  localparam logic [CW-1:0] WIN_BOTTOM_RST = CW'(819);
  localparam logic [CW-1:0] WIN_RIGHT_RST  = CW'(2048);
  localparam logic [CW-1:0] WIN_TOP_RST    = CW'(2048);

  localparam logic [1:0] CFG_LEFT   = 2'd0;
  localparam logic [1:0] CFG_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_RIGHT  = 2'd2;
  localparam logic [1:0] CFG_TOP    = 2'd3;

  localparam logic [3:0] RGN_INSIDE = 4'd0;
  localparam logic [3:0] RGN_UP     = 4'd1;
  localparam logic [3:0] RGN_DOWN   = 4'd2;
  localparam logic [3:0] RGN_LEFT   = 4'd3;
  localparam logic [3:0] RGN_RIGHT  = 4'd4;
  localparam logic [3:0] RGN_UL     = 4'd5;
  localparam logic [3:0] RGN_UR     = 4'd6;
  localparam logic [3:0] RGN_DL     = 4'd7;
  localparam logic [3:0] RGN_DR     = 4'd8;

  // one edge-intersection candidate travelling beside its division
  typedef struct packed {
    logic                 live;
    logic                 neg;
    logic signed [CW-1:0] base;
    logic signed [CW-1:0] edge_pos;
  } cand_t;

endpackage

// ===== rtl/core/rwlc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module rwlc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rwlc_pkg::NUMW-1:0]     num_i,
  input  logic [rwlc_pkg::DENW-1:0]     den_i,
  input  rwlc_pkg::cand_t               cand_i,
  output logic [rwlc_pkg::NUMW-1:0]     quo_o,
  output rwlc_pkg::cand_t               cand_o
);

  logic [rwlc_pkg::DENW-1:0] rem_r [rwlc_pkg::DIV_STAGES];
  logic [rwlc_pkg::NUMW-1:0] nq_r  [rwlc_pkg::DIV_STAGES];
  logic [rwlc_pkg::DENW-1:0] den_r [rwlc_pkg::DIV_STAGES];
  rwlc_pkg::cand_t           cand_r[rwlc_pkg::DIV_STAGES];

  logic [rwlc_pkg::DENW-1:0] rem_nxt [rwlc_pkg::DIV_STAGES];
  logic [rwlc_pkg::NUMW-1:0] nq_nxt  [rwlc_pkg::DIV_STAGES];
  logic [rwlc_pkg::DENW-1:0] src_rem [rwlc_pkg::DIV_STAGES];
  logic [rwlc_pkg::NUMW-1:0] src_nq  [rwlc_pkg::DIV_STAGES];
  logic [rwlc_pkg::DENW-1:0] src_den [rwlc_pkg::DIV_STAGES];
  rwlc_pkg::cand_t           src_cand[rwlc_pkg::DIV_STAGES];
  logic [rwlc_pkg::DENW:0]   trial   [rwlc_pkg::DIV_STAGES];

  for (genvar s = 0; s < rwlc_pkg::DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src_rem[s]  = '0;
      assign src_nq[s]   = num_i;
      assign src_den[s]  = den_i;
      assign src_cand[s] = cand_i;
    end else begin : g_next
      assign src_rem[s]  = rem_r[s-1];
      assign src_nq[s]   = nq_r[s-1];
      assign src_den[s]  = den_r[s-1];
      assign src_cand[s] = cand_r[s-1];
    end

    always_comb begin
      trial[s] = {src_rem[s], src_nq[s][rwlc_pkg::NUMW-1]};
      if (trial[s] >= {1'b0, src_den[s]}) begin
        rem_nxt[s] = rwlc_pkg::DENW'(trial[s] - {1'b0, src_den[s]});
        nq_nxt[s]  = {src_nq[s][rwlc_pkg::NUMW-2:0], 1'b1};
      end else begin
        rem_nxt[s] = rwlc_pkg::DENW'(trial[s]);
        nq_nxt[s]  = {src_nq[s][rwlc_pkg::NUMW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt[s];
        nq_r[s]   <= nq_nxt[s];
        den_r[s]  <= src_den[s];
        cand_r[s] <= src_cand[s];
      end
    end
  end

  assign quo_o  = nq_r[rwlc_pkg::DIV_STAGES-1];
  assign cand_o = cand_r[rwlc_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/rect_window_line_clipper_top.sv =====
// Line clipper against a rectangular window: takes one segment per cycle and
// returns it with each endpoint moved onto the window edge of its outside
// region, with both region codes and a visible flag. The pipeline is fully
// stalled as one when a finished result is held, and otherwise accepts a new
// segment every clock. The four bit-per-stage dividers produce the rounded
// edge intersections. Window registers may be written only while no
// segment is in flight.
module rect_window_line_clipper_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rwlc_pkg::CW-1:0]       cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [rwlc_pkg::CW-1:0] in_start_x,
  input  logic signed [rwlc_pkg::CW-1:0] in_start_y,
  input  logic signed [rwlc_pkg::CW-1:0] in_end_x,
  input  logic signed [rwlc_pkg::CW-1:0] in_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rwlc_pkg::CW-1:0] out_clipped_start_x,
  output logic signed [rwlc_pkg::CW-1:0] out_clipped_start_y,
  output logic signed [rwlc_pkg::CW-1:0] out_clipped_end_x,
  output logic signed [rwlc_pkg::CW-1:0] out_clipped_end_y,
  output logic [3:0]                    out_start_region,
  output logic [3:0]                    out_end_region,
  output logic                          out_visible
);

  localparam int CW = rwlc_pkg::CW;
  localparam int DW = rwlc_pkg::DW;
  localparam int PW = rwlc_pkg::PW;
  localparam int NUMW = rwlc_pkg::NUMW;
  localparam int DENW = rwlc_pkg::DENW;
  localparam int SW = rwlc_pkg::SW;
  localparam int DLEN = rwlc_pkg::DIV_STAGES;

  typedef struct packed {
    logic                 vld;
    logic [3:0]           ra;
    logic [3:0]           rb;
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    logic signed [CW-1:0] xb;
    logic signed [CW-1:0] yb;
  } item_t;

  logic signed [CW-1:0] win_l_r, win_b_r, win_r_r, win_t_r;
  logic en;

  assign in_stall = out_valid & out_stall;
  assign en = ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= rwlc_pkg::WIN_LEFT_RST;
      win_b_r <= rwlc_pkg::WIN_BOTTOM_RST;
      win_r_r <= rwlc_pkg::WIN_RIGHT_RST;
      win_t_r <= rwlc_pkg::WIN_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rwlc_pkg::CFG_LEFT:   win_l_r <= cfg_wdata;
        rwlc_pkg::CFG_BOTTOM: win_b_r <= cfg_wdata;
        rwlc_pkg::CFG_RIGHT:  win_r_r <= cfg_wdata;
        rwlc_pkg::CFG_TOP:    win_t_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic [3:0] classify(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] l,
                                          input logic signed [CW-1:0] b,
                                          input logic signed [CW-1:0] r,
                                          input logic signed [CW-1:0] t);
    logic [3:0] rg;
    if (x > l && x < r && y > b && y < t) rg = rwlc_pkg::RGN_INSIDE;
    else if (x <= l && y >= t) rg = rwlc_pkg::RGN_UL;
    else if (x >= r && y >= t) rg = rwlc_pkg::RGN_UR;
    else if (x <= l && y <= b) rg = rwlc_pkg::RGN_DL;
    else if (x >= r && y <= b) rg = rwlc_pkg::RGN_DR;
    else if (y >= t) rg = rwlc_pkg::RGN_UP;
    else if (y <= b) rg = rwlc_pkg::RGN_DOWN;
    else if (x >= r) rg = rwlc_pkg::RGN_RIGHT;
    else rg = rwlc_pkg::RGN_LEFT;
    return rg;
  endfunction

  function automatic logic signed [DW-1:0] sub_ext(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
  endfunction

  // stage 0: input register
  item_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.vld <= 1'b0;
    else if (en) s0_r.vld <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.xa <= in_start_x;
      s0_r.ya <= in_start_y;
      s0_r.xb <= in_end_x;
      s0_r.yb <= in_end_y;
      s0_r.ra <= '0;
      s0_r.rb <= '0;
    end
  end

  // stage 1: classify and set up the four candidates
  // order: start vertical, start horizontal, end vertical, end horizontal
  item_t s1_nxt, s1_r;
  logic signed [DW-1:0] n_nxt [4];
  logic signed [DW-1:0] m_nxt [4];
  logic signed [DW-1:0] d_nxt [4];
  rwlc_pkg::cand_t      c1_nxt[4];
  logic signed [DW-1:0] n1_r [4];
  logic signed [DW-1:0] m1_r [4];
  logic signed [DW-1:0] d1_r [4];
  rwlc_pkg::cand_t      c1_r [4];
  logic [3:0] rgn_k [4];
  logic       vert_try [4];
  logic       horz_try [4];
  logic signed [CW-1:0] vx_k [4];
  logic signed [CW-1:0] hy_k [4];

  always_comb begin
    s1_nxt = s0_r;
    s1_nxt.ra = classify(s0_r.xa, s0_r.ya, win_l_r, win_b_r, win_r_r, win_t_r);
    s1_nxt.rb = classify(s0_r.xb, s0_r.yb, win_l_r, win_b_r, win_r_r, win_t_r);
    for (int k = 0; k < 4; k++) begin
      rgn_k[k] = (k < 2) ? s1_nxt.ra : s1_nxt.rb;
      vert_try[k] = rgn_k[k] inside {rwlc_pkg::RGN_LEFT, rwlc_pkg::RGN_RIGHT,
                                     rwlc_pkg::RGN_UL, rwlc_pkg::RGN_UR,
                                     rwlc_pkg::RGN_DL, rwlc_pkg::RGN_DR};
      horz_try[k] = rgn_k[k] inside {rwlc_pkg::RGN_UP, rwlc_pkg::RGN_DOWN,
                                     rwlc_pkg::RGN_UL, rwlc_pkg::RGN_UR,
                                     rwlc_pkg::RGN_DL, rwlc_pkg::RGN_DR};
      vx_k[k] = (rgn_k[k] inside {rwlc_pkg::RGN_LEFT, rwlc_pkg::RGN_UL,
                                  rwlc_pkg::RGN_DL}) ? win_l_r : win_r_r;
      hy_k[k] = (rgn_k[k] inside {rwlc_pkg::RGN_UP, rwlc_pkg::RGN_UL,
                                  rwlc_pkg::RGN_UR}) ? win_t_r : win_b_r;
      c1_nxt[k].neg = 1'b0;
      if (k % 2 == 0) begin
        d_nxt[k] = sub_ext(s0_r.xb, s0_r.xa);
        n_nxt[k] = sub_ext(s0_r.yb, s0_r.ya);
        m_nxt[k] = sub_ext(vx_k[k], s0_r.xa);
        c1_nxt[k].base = s0_r.ya;
        c1_nxt[k].edge_pos = vx_k[k];
        c1_nxt[k].live = vert_try[k] && (d_nxt[k] != '0);
      end else begin
        d_nxt[k] = sub_ext(s0_r.yb, s0_r.ya);
        n_nxt[k] = sub_ext(s0_r.xb, s0_r.xa);
        m_nxt[k] = sub_ext(hy_k[k], s0_r.ya);
        c1_nxt[k].base = s0_r.xa;
        c1_nxt[k].edge_pos = hy_k[k];
        c1_nxt[k].live = horz_try[k] && (d_nxt[k] != '0);
      end
    end
  end

  // stage 2: products
  item_t s2_r;
  logic signed [PW-1:0] p2_r [4];
  logic signed [DW-1:0] d2_r [4];
  rwlc_pkg::cand_t      c2_r [4];

  // stage 3: magnitudes, rounding offset and sign
  item_t s3_r;
  logic [NUMW-1:0]      num3_r [4];
  logic [DENW-1:0]      den3_r [4];
  rwlc_pkg::cand_t      c3_r   [4];
  logic [NUMW-1:0]      num3_nxt [4];
  logic [DENW-1:0]      den3_nxt [4];
  rwlc_pkg::cand_t      c3_nxt   [4];
  logic [PW-1:0]        absp [4];
  logic [DW-1:0]        absd [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      absp[k] = p2_r[k][PW-1] ? PW'(-p2_r[k]) : PW'(p2_r[k]);
      absd[k] = d2_r[k][DW-1] ? DW'(-d2_r[k]) : DW'(d2_r[k]);
      // 2|p| + |d| over 2|d| gives round half away from zero
      num3_nxt[k] = NUMW'({absp[k][2*CW-1:0], 1'b0}) + NUMW'(absd[k][CW-1:0]);
      den3_nxt[k] = {absd[k][CW-1:0], 1'b0};
      c3_nxt[k] = c2_r[k];
      c3_nxt[k].neg = p2_r[k][PW-1] ^ d2_r[k][DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
    end else if (en) begin
      s1_r.vld <= s1_nxt.vld;
      s2_r.vld <= s1_r.vld;
      s3_r.vld <= s2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.ra <= s1_nxt.ra;
      s1_r.rb <= s1_nxt.rb;
      s1_r.xa <= s1_nxt.xa;
      s1_r.ya <= s1_nxt.ya;
      s1_r.xb <= s1_nxt.xb;
      s1_r.yb <= s1_nxt.yb;
      s2_r.ra <= s1_r.ra;
      s2_r.rb <= s1_r.rb;
      s2_r.xa <= s1_r.xa;
      s2_r.ya <= s1_r.ya;
      s2_r.xb <= s1_r.xb;
      s2_r.yb <= s1_r.yb;
      s3_r.ra <= s2_r.ra;
      s3_r.rb <= s2_r.rb;
      s3_r.xa <= s2_r.xa;
      s3_r.ya <= s2_r.ya;
      s3_r.xb <= s2_r.xb;
      s3_r.yb <= s2_r.yb;
      for (int k = 0; k < 4; k++) begin
        n1_r[k] <= n_nxt[k];
        m1_r[k] <= m_nxt[k];
        d1_r[k] <= d_nxt[k];
        c1_r[k] <= c1_nxt[k];
        p2_r[k] <= PW'(n1_r[k]) * PW'(m1_r[k]);
        d2_r[k] <= d1_r[k];
        c2_r[k] <= c1_r[k];
        num3_r[k] <= num3_nxt[k];
        den3_r[k] <= den3_nxt[k];
        c3_r[k] <= c3_nxt[k];
      end
    end
  end

  // dividers
  logic [NUMW-1:0]  quo [4];
  rwlc_pkg::cand_t  cq  [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    rwlc_div u_div (
      .clk    (clk),
      .en     (en),
      .num_i  (num3_r[k]),
      .den_i  (den3_r[k]),
      .cand_i (c3_r[k]),
      .quo_o  (quo[k]),
      .cand_o (cq[k])
    );
  end

  // item details follow the dividers
  item_t dl_r [DLEN];
  for (genvar s = 0; s < DLEN; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) dl_r[s].vld <= 1'b0;
      else if (en) dl_r[s].vld <= (s == 0) ? s3_r.vld : dl_r[(s == 0) ? 0 : s-1].vld;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (s == 0) begin
          dl_r[s].ra <= s3_r.ra;
          dl_r[s].rb <= s3_r.rb;
          dl_r[s].xa <= s3_r.xa;
          dl_r[s].ya <= s3_r.ya;
          dl_r[s].xb <= s3_r.xb;
          dl_r[s].yb <= s3_r.yb;
        end else begin
          dl_r[s].ra <= dl_r[(s == 0) ? 0 : s-1].ra;
          dl_r[s].rb <= dl_r[(s == 0) ? 0 : s-1].rb;
          dl_r[s].xa <= dl_r[(s == 0) ? 0 : s-1].xa;
          dl_r[s].ya <= dl_r[(s == 0) ? 0 : s-1].ya;
          dl_r[s].xb <= dl_r[(s == 0) ? 0 : s-1].xb;
          dl_r[s].yb <= dl_r[(s == 0) ? 0 : s-1].yb;
        end
      end
    end
  end

  // stage 4: intersection coordinate along the other axis
  item_t s4_r;
  logic signed [SW-1:0] crd4_r [4];
  rwlc_pkg::cand_t      c4_r   [4];
  logic signed [SW-1:0] crd4_nxt [4];
  logic [SW-1:0]        sq [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq[k] = cq[k].neg ? SW'(-{2'b00, quo[k]}) : {2'b00, quo[k]};
      crd4_nxt[k] = $signed({{(SW-CW){cq[k].base[CW-1]}}, cq[k].base}) + $signed(sq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_r.vld <= 1'b0;
    else if (en) s4_r.vld <= dl_r[DLEN-1].vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_r.ra <= dl_r[DLEN-1].ra;
      s4_r.rb <= dl_r[DLEN-1].rb;
      s4_r.xa <= dl_r[DLEN-1].xa;
      s4_r.ya <= dl_r[DLEN-1].ya;
      s4_r.xb <= dl_r[DLEN-1].xb;
      s4_r.yb <= dl_r[DLEN-1].yb;
      for (int k = 0; k < 4; k++) begin
        crd4_r[k] <= crd4_nxt[k];
        c4_r[k] <= cq[k];
      end
    end
  end

  // stage 5: window test, selection and output register
  logic signed [SW-1:0] wl_x, wb_x, wr_x, wt_x;
  logic hit [4];
  logic ok_a, ok_b, vis;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic out_valid_r;
  logic signed [CW-1:0] osx_r, osy_r, oex_r, oey_r;
  logic [3:0] osr_r, oer_r;
  logic ovis_r;

  always_comb begin
    wl_x = $signed({{(SW-CW){win_l_r[CW-1]}}, win_l_r});
    wb_x = $signed({{(SW-CW){win_b_r[CW-1]}}, win_b_r});
    wr_x = $signed({{(SW-CW){win_r_r[CW-1]}}, win_r_r});
    wt_x = $signed({{(SW-CW){win_t_r[CW-1]}}, win_t_r});
    for (int k = 0; k < 4; k++) begin
      if (k % 2 == 0) begin
        hit[k] = c4_r[k].live && c4_r[k].edge_pos >= win_l_r && c4_r[k].edge_pos <= win_r_r
                 && crd4_r[k] >= wb_x && crd4_r[k] <= wt_x;
      end else begin
        hit[k] = c4_r[k].live && c4_r[k].edge_pos >= win_b_r && c4_r[k].edge_pos <= win_t_r
                 && crd4_r[k] >= wl_x && crd4_r[k] <= wr_x;
      end
    end
    // horizontal edge hit wins over the vertical one
    if (s4_r.ra == rwlc_pkg::RGN_INSIDE) begin
      ok_a = 1'b1;  ax = s4_r.xa;  ay = s4_r.ya;
    end else if (hit[1]) begin
      ok_a = 1'b1;  ax = CW'(crd4_r[1]);  ay = c4_r[1].edge_pos;
    end else begin
      ok_a = hit[0];  ax = c4_r[0].edge_pos;  ay = CW'(crd4_r[0]);
    end
    if (s4_r.rb == rwlc_pkg::RGN_INSIDE) begin
      ok_b = 1'b1;  bx = s4_r.xb;  by = s4_r.yb;
    end else if (hit[3]) begin
      ok_b = 1'b1;  bx = CW'(crd4_r[3]);  by = c4_r[3].edge_pos;
    end else begin
      ok_b = hit[2];  bx = c4_r[2].edge_pos;  by = CW'(crd4_r[2]);
    end
    vis = ok_a & ok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= s4_r.vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      osx_r  <= vis ? ax : '0;
      osy_r  <= vis ? ay : '0;
      oex_r  <= vis ? bx : '0;
      oey_r  <= vis ? by : '0;
      osr_r  <= s4_r.ra;
      oer_r  <= s4_r.rb;
      ovis_r <= vis;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_clipped_start_x = osx_r;
  assign out_clipped_start_y = osy_r;
  assign out_clipped_end_x   = oex_r;
  assign out_clipped_end_y   = oey_r;
  assign out_start_region    = osr_r;
  assign out_end_region      = oer_r;
  assign out_visible         = ovis_r;

endmodule
